// ===== rtl/gsp_pkg.sv =====
// gsp_pkg: shared types and constants of the goal seeking proportional controller
// beat structs for the tick and command channels, configuration layout, product stage record
// no dependencies
`default_nettype none

package gsp_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_W  = 31;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned PROD_W = 64;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MAX_SPEED_X     = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_SPEED_Y     = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_SPEED_YAW   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_X          = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_Y          = 3'd4;
	localparam logic [IDX_W-1:0] REG_GAIN_YAW        = 3'd5;
	localparam logic [IDX_W-1:0] REG_DIST_TOLERANCE  = 3'd6;
	localparam logic [IDX_W-1:0] REG_ANGLE_TOLERANCE = 3'd7;

	// action codes
	localparam logic ACT_GOAL = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] goal_x;
		logic signed [DATA_W-1:0] goal_y;
		logic signed [DATA_W-1:0] yaw_error;
		logic                     pose_valid;
	} tick_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_yaw;
		logic                     arrived;
	} cmd_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_speed_x;
		logic [CFG_W-1:0] max_speed_y;
		logic [CFG_W-1:0] max_speed_yaw;
		logic [CFG_W-1:0] gain_x;
		logic [CFG_W-1:0] gain_y;
		logic [CFG_W-1:0] gain_yaw;
		logic [CFG_W-1:0] dist_tolerance;
		logic [CFG_W-1:0] angle_tolerance;
	} cfg_t;

	// products and flags handed from the multiply stage to the decision stage
	typedef struct packed {
		logic              action;
		logic              pose_valid;
		logic [PROD_W-1:0] xx;
		logic [PROD_W-1:0] yy;
		logic [PROD_W-1:0] tol2;
		logic [PROD_W-2:0] px;
		logic [PROD_W-2:0] py;
		logic [PROD_W-2:0] pyaw;
		logic              neg_x;
		logic              neg_y;
		logic              neg_yaw;
		logic              yaw_small;
	} prod_t;

endpackage

`default_nettype wire

// ===== rtl/gsp_prod.sv =====
// gsp_prod: multiply stage, magnitudes and all products of one tick beat
// uses gsp_pkg for beat, configuration and product types
`default_nettype none

module gsp_prod (
	input  var gsp_pkg::tick_beat_t tick,
	input  var gsp_pkg::cfg_t       cfg,
	output gsp_pkg::prod_t          prod
);

	logic [gsp_pkg::DATA_W-1:0] mag_x;
	logic [gsp_pkg::DATA_W-1:0] mag_y;
	logic [gsp_pkg::DATA_W-1:0] mag_yaw;

	// two's complement negate in 32 bits also covers the most negative value
	assign mag_x   = tick.goal_x[31]    ? (~tick.goal_x + 32'd1)    : tick.goal_x;
	assign mag_y   = tick.goal_y[31]    ? (~tick.goal_y + 32'd1)    : tick.goal_y;
	assign mag_yaw = tick.yaw_error[31] ? (~tick.yaw_error + 32'd1) : tick.yaw_error;

	always_comb begin
		prod.action     = tick.action;
		prod.pose_valid = tick.pose_valid;
		prod.xx         = 64'(mag_x) * 64'(mag_x);
		prod.yy         = 64'(mag_y) * 64'(mag_y);
		prod.tol2       = 64'(cfg.dist_tolerance) * 64'(cfg.dist_tolerance);
		prod.px         = 63'(cfg.gain_x) * 63'(mag_x);
		prod.py         = 63'(cfg.gain_y) * 63'(mag_y);
		prod.pyaw       = 63'(cfg.gain_yaw) * 63'(mag_yaw);
		prod.neg_x      = tick.goal_x[31];
		prod.neg_y      = tick.goal_y[31];
		prod.neg_yaw    = tick.yaw_error[31];
		prod.yaw_small  = mag_yaw < {1'b0, cfg.angle_tolerance};
	end

endmodule

`default_nettype wire

// ===== rtl/gsp_sat.sv =====
// gsp_sat: fixed point rescale with floor rounding and symmetric clamp
// uses gsp_pkg for widths
`default_nettype none

module gsp_sat #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  var logic [gsp_pkg::PROD_W-2:0]        mag_prod,
	input  var logic                              neg,
	input  var logic [gsp_pkg::CFG_W-1:0]         limit,
	output logic signed [gsp_pkg::DATA_W-1:0]     vel
);

	localparam logic [gsp_pkg::PROD_W-1:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

	logic [gsp_pkg::PROD_W-1:0] biased;
	logic [gsp_pkg::PROD_W-1:0] q;
	logic [gsp_pkg::CFG_W-1:0]  mag;

	// negative values round the magnitude up, which is floor on the signed value
	assign biased = neg ? ({1'b0, mag_prod} + RND) : {1'b0, mag_prod};
	assign q      = biased >> FRAC_BITS;
	assign mag    = (q > {33'd0, limit}) ? limit : q[gsp_pkg::CFG_W-1:0];
	assign vel    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

`default_nettype wire

// ===== rtl/goal_seek_p_controller.sv =====
// goal_seek_p_controller: proportional goal seeker with saturated velocity commands
// top level: configuration registers, three stage pipeline, arming flag
// depends on gsp_pkg, gsp_prod, gsp_sat
//
// usage
//   tick channel (tick_valid / tick_stall / tick): one beat per goal or control tick.
//   action goal arms the block and produces no command. action tick, while armed
//   and with pose_valid set, produces exactly one command beat; otherwise none.
//   cmd channel (cmd_valid / cmd_stall / cmd): velocity commands and arrival flag.
//   cfg port: cfg_we writes cfg_data into register cfg_index at the clock edge;
//   write only while no beat is in flight.
// pipeline and throughput
//   a command beat passes the input register, the multiply register (all products)
//   and the result register on its way from its tick beat to cmd.
//   one beat per cycle sustained while no command is stalled, and the arming flag is
//   read and updated in the decision stage only, in beat order.
// stall
//   stall ripples back stage by stage; empty stages still fill while cmd waits,
//   so up to two more beats are taken behind a stalled command.
// reset
//   arst_n clears the pipeline valids and the arming flag and loads the
//   configuration defaults (limits 1.0 / 1.0 / 2.0, gains 1.0, tolerances 0.1 / 0.05).
`default_nettype none

module goal_seek_p_controller #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  var logic                              clk,
	input  var logic                              arst_n,
	input  var logic                              tick_valid,
	output logic                                  tick_stall,
	input  var gsp_pkg::tick_beat_t               tick,
	output logic                                  cmd_valid,
	input  var logic                              cmd_stall,
	output gsp_pkg::cmd_beat_t                    cmd,
	input  var logic                              cfg_we,
	input  var logic [gsp_pkg::IDX_W-1:0]         cfg_index,
	input  var logic [gsp_pkg::CFG_W-1:0]         cfg_data
);

	// configuration defaults at the chosen fraction width, rounded to nearest
	localparam logic [gsp_pkg::CFG_W-1:0] RST_ONE  = 31'(64'd1 << FRAC_BITS);
	localparam logic [gsp_pkg::CFG_W-1:0] RST_TWO  = 31'(64'd2 << FRAC_BITS);
	localparam logic [gsp_pkg::CFG_W-1:0] RST_DIST =
		31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [gsp_pkg::CFG_W-1:0] RST_ANG  =
		31'(((64'd1 << FRAC_BITS) * 64'd5 + 64'd50) / 64'd100);

	gsp_pkg::cfg_t       cfg_q;
	gsp_pkg::tick_beat_t tick_s1;
	gsp_pkg::prod_t      prod_d;
	gsp_pkg::prod_t      prod_s2;
	gsp_pkg::cmd_beat_t  cmd_q;
	gsp_pkg::cmd_beat_t  cmd_d;
	logic                v_s1;
	logic                v_s2;
	logic                cmd_valid_q;
	logic                plan_active_q;

	logic                rdy_out;
	logic                rdy_s2;
	logic                rdy_s1;
	logic                adv_s2;
	logic [gsp_pkg::PROD_W-1:0] d2;
	logic                near;
	logic                has_result;
	logic                arrive;
	logic signed [gsp_pkg::DATA_W-1:0] sat_x;
	logic signed [gsp_pkg::DATA_W-1:0] sat_y;
	logic signed [gsp_pkg::DATA_W-1:0] sat_yaw;

	// ready chain: a stage moves when empty or when the one ahead moves
	assign rdy_out    = !cmd_valid_q || !cmd_stall;
	assign rdy_s2     = !v_s2 || rdy_out;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign adv_s2     = v_s2 && rdy_out;
	assign tick_stall = !rdy_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed_x     <= RST_ONE;
			cfg_q.max_speed_y     <= RST_ONE;
			cfg_q.max_speed_yaw   <= RST_TWO;
			cfg_q.gain_x          <= RST_ONE;
			cfg_q.gain_y          <= RST_ONE;
			cfg_q.gain_yaw        <= RST_ONE;
			cfg_q.dist_tolerance  <= RST_DIST;
			cfg_q.angle_tolerance <= RST_ANG;
		end else if (cfg_we) begin
			case (cfg_index)
				gsp_pkg::REG_MAX_SPEED_X:     cfg_q.max_speed_x     <= cfg_data;
				gsp_pkg::REG_MAX_SPEED_Y:     cfg_q.max_speed_y     <= cfg_data;
				gsp_pkg::REG_MAX_SPEED_YAW:   cfg_q.max_speed_yaw   <= cfg_data;
				gsp_pkg::REG_GAIN_X:          cfg_q.gain_x          <= cfg_data;
				gsp_pkg::REG_GAIN_Y:          cfg_q.gain_y          <= cfg_data;
				gsp_pkg::REG_GAIN_YAW:        cfg_q.gain_yaw        <= cfg_data;
				gsp_pkg::REG_DIST_TOLERANCE:  cfg_q.dist_tolerance  <= cfg_data;
				gsp_pkg::REG_ANGLE_TOLERANCE: cfg_q.angle_tolerance <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	// stage 2: products
	gsp_prod u_prod (
		.tick (tick_s1),
		.cfg  (cfg_q),
		.prod (prod_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_d;
		end
	end

	// decision stage: distance test, rescale and clamp
	assign d2         = prod_s2.xx + prod_s2.yy;
	assign near       = d2 <= prod_s2.tol2;
	assign has_result = (prod_s2.action == gsp_pkg::ACT_TICK) && plan_active_q &&
		prod_s2.pose_valid;
	assign arrive     = has_result && near && prod_s2.yaw_small;

	gsp_sat #(.FRAC_BITS(FRAC_BITS)) u_sat_x (
		.mag_prod (prod_s2.px),
		.neg      (prod_s2.neg_x),
		.limit    (cfg_q.max_speed_x),
		.vel      (sat_x)
	);

	gsp_sat #(.FRAC_BITS(FRAC_BITS)) u_sat_y (
		.mag_prod (prod_s2.py),
		.neg      (prod_s2.neg_y),
		.limit    (cfg_q.max_speed_y),
		.vel      (sat_y)
	);

	gsp_sat #(.FRAC_BITS(FRAC_BITS)) u_sat_yaw (
		.mag_prod (prod_s2.pyaw),
		.neg      (prod_s2.neg_yaw),
		.limit    (cfg_q.max_speed_yaw),
		.vel      (sat_yaw)
	);

	// far: drive x and y; near: turn in place, or stop and report arrival
	always_comb begin
		cmd_d.vel_x   = near ? '0 : sat_x;
		cmd_d.vel_y   = near ? '0 : sat_y;
		cmd_d.vel_yaw = (near && !prod_s2.yaw_small) ? sat_yaw : '0;
		cmd_d.arrived = near && prod_s2.yaw_small;
	end

	// arming flag, updated only as a beat leaves the decision stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_active_q <= 1'b0;
		end else if (adv_s2) begin
			if (prod_s2.action == gsp_pkg::ACT_GOAL) begin
				plan_active_q <= 1'b1;
			end else if (arrive) begin
				plan_active_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (rdy_out) begin
			cmd_valid_q <= v_s2 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && has_result) begin
			cmd_q <= cmd_d;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

endmodule

`default_nettype wire

// ===== rtl/gsp_checker.sv =====
// gsp_checker: port level checks of the goal seeking controller
// bound to goal_seek_p_controller; uses gsp_pkg for beat types
`default_nettype none

module gsp_checker (
	input var logic                      clk,
	input var logic                      arst_n,
	input var logic                      tick_stall,
	input var logic                      cmd_valid,
	input var logic                      cmd_stall,
	input var gsp_pkg::cmd_beat_t        cmd
);

	// a stalled command beat holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("command beat changed under stall");

	// arrival carries a zero command
	a_arrive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.arrived |->
			cmd.vel_x == 32'sd0 && cmd.vel_y == 32'sd0 && cmd.vel_yaw == 32'sd0)
		else $error("arrival with nonzero velocity");

	// either driving or turning, never both
	a_drive_or_turn: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd.arrived |->
			cmd.vel_yaw == 32'sd0 || (cmd.vel_x == 32'sd0 && cmd.vel_y == 32'sd0))
		else $error("translation and turn in one command");

	// a second arrival needs a new goal beat first, so never back to back
	a_arrive_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.arrived |=> !(cmd_valid && cmd.arrived))
		else $error("arrival reported on consecutive beats");

	// the input only backs up behind a stalled command beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> cmd_valid && cmd_stall)
		else $error("tick stalled with no stalled command");

endmodule

bind goal_seek_p_controller gsp_checker u_gsp_checker (.*);

`default_nettype wire

// ===== tb/goal_seek_p_controller_tb.sv =====
// goal_seek_p_controller_tb: self-checking testbench of the goal seeking proportional controller
// drives random goal and tick beats under bursty traffic and receiver stalls, predicts every command
// depends on gsp_pkg and goal_seek_p_controller
`default_nettype none

module goal_seek_p_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [gsp_pkg::CFG_W-1:0] cfg_word_t;
	typedef logic [gsp_pkg::IDX_W-1:0] cfg_idx_t;

	localparam int unsigned FRAC_BITS       = 16;
	localparam int          ITEMS_PER_PHASE = 95;
	localparam int          SETTLE_CYCLES   = 8;
	localparam int          LIMIT_CYCLES    = 400000;
	localparam longint      S32_MAX         = 64'sh7fff_ffff;
	localparam longint      S32_MIN         = -64'sh8000_0000;
	localparam cfg_word_t   CFG_ONES        = '1;
	localparam cfg_word_t   ONE_Q           = cfg_word_t'(1) << FRAC_BITS;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
	typedef enum {SET_ALL_ONES, SET_ALL_ZERO, SET_TYPICAL, SET_RAW, SET_FINE_GAIN,
		SET_DEFAULT} setting_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_stall;
	gsp_pkg::tick_beat_t  tick       = '0;
	logic                 cmd_valid;
	logic                 cmd_stall  = 1'b0;
	gsp_pkg::cmd_beat_t   cmd;
	logic                 cfg_we     = 1'b0;
	cfg_idx_t             cfg_index  = '0;
	cfg_word_t            cfg_data   = '0;

	// predictor state: register copy and arming flag
	cfg_word_t        cfg_shadow [8];
	logic             armed;

	gsp_pkg::tick_beat_t tick_backlog [$];
	gsp_pkg::cmd_beat_t  expected_cmds [$];

	int accepted_cnt = 0;
	int drained_cnt  = 0;
	int fail_count   = 0;
	int n_checked    = 0;
	int n_moving     = 0;
	int n_turning    = 0;
	int n_arrivals   = 0;
	int n_random     = 0;
	int cycle_cnt    = 0;

	goal_seek_p_controller #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// fixed point helpers of the predictor
	// ---------------------------------------------------------------

	// exact magnitude, so the most negative value gives 2^31
	function automatic logic [63:0] magnitude(logic signed [31:0] v);
		return v[31] ? 64'(-longint'(v)) : 64'(longint'(v));
	endfunction

	// gain times value, floor of the shift by the fraction bits, clamped to +/- limit
	function automatic logic signed [31:0] drive_term(cfg_word_t gain,
			logic signed [31:0] v, cfg_word_t limit);
		logic [63:0] prod;
		longint      r;
		longint      lim;
		prod = 64'(gain) * magnitude(v);
		// floor of a negative quotient is minus the ceiling of its magnitude
		if (v < 0) begin
			r = -longint'((prod + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS);
		end else begin
			r = longint'(prod >> FRAC_BITS);
		end
		lim = longint'(64'(limit));
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[31:0];
	endfunction

	// works out the command caused by one accepted beat, if any
	function automatic void predict_command(gsp_pkg::tick_beat_t b);
		gsp_pkg::cmd_beat_t c;
		logic [63:0]        dist2;
		logic [63:0]        tol2;
		if (b.action == gsp_pkg::ACT_GOAL) begin
			armed = 1'b1;
			return;
		end
		// idle ticks and ticks without a pose leave no trace
		if (!armed || !b.pose_valid) return;
		c = '0;
		dist2 = magnitude(b.goal_x) * magnitude(b.goal_x)
			+ magnitude(b.goal_y) * magnitude(b.goal_y);
		tol2 = 64'(cfg_shadow[gsp_pkg::REG_DIST_TOLERANCE])
			* 64'(cfg_shadow[gsp_pkg::REG_DIST_TOLERANCE]);
		if (dist2 <= tol2) begin
			// inside the distance bound: turn until the yaw error is strictly small
			if (magnitude(b.yaw_error) < 64'(cfg_shadow[gsp_pkg::REG_ANGLE_TOLERANCE])) begin
				armed = 1'b0;
				c.arrived = 1'b1;
				n_arrivals++;
			end else begin
				c.vel_yaw = drive_term(cfg_shadow[gsp_pkg::REG_GAIN_YAW], b.yaw_error,
					cfg_shadow[gsp_pkg::REG_MAX_SPEED_YAW]);
				n_turning++;
			end
		end else begin
			c.vel_x = drive_term(cfg_shadow[gsp_pkg::REG_GAIN_X], b.goal_x,
				cfg_shadow[gsp_pkg::REG_MAX_SPEED_X]);
			c.vel_y = drive_term(cfg_shadow[gsp_pkg::REG_GAIN_Y], b.goal_y,
				cfg_shadow[gsp_pkg::REG_MAX_SPEED_Y]);
			n_moving++;
		end
		expected_cmds.push_back(c);
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic logic signed [31:0] sat32(longint v);
		if (v > S32_MAX) begin
			v = S32_MAX;
		end else if (v < S32_MIN) begin
			v = S32_MIN;
		end
		return v[31:0];
	endfunction

	// uniform value in [-span, span]
	function automatic longint spread(longint span);
		longint s;
		longint v;
		s = span;
		if (s > S32_MAX) s = S32_MAX;
		if (s < 0) s = 0;
		v = longint'($urandom_range(0, 32'(s)));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic gsp_pkg::tick_beat_t make_beat(logic act, longint x, longint y,
			longint yaw, logic pv);
		gsp_pkg::tick_beat_t b;
		b.action     = act;
		b.goal_x     = sat32(x);
		b.goal_y     = sat32(y);
		b.yaw_error  = sat32(yaw);
		b.pose_valid = pv;
		return b;
	endfunction

	// goal beat with junk in the data fields, which the block ignores
	function automatic gsp_pkg::tick_beat_t goal_beat();
		gsp_pkg::tick_beat_t b;
		b.action     = gsp_pkg::ACT_GOAL;
		b.goal_x     = $urandom;
		b.goal_y     = $urandom;
		b.yaw_error  = $urandom;
		b.pose_valid = 1'($urandom_range(0, 1));
		return b;
	endfunction

	// valid tick, positions and yaw spread around the current tolerances
	function automatic gsp_pkg::tick_beat_t random_tick();
		gsp_pkg::tick_beat_t b;
		int                  r;
		longint              tol;
		longint              ang;
		longint              edge_v;
		tol = longint'(64'(cfg_shadow[gsp_pkg::REG_DIST_TOLERANCE]));
		ang = longint'(64'(cfg_shadow[gsp_pkg::REG_ANGLE_TOLERANCE]));
		b.action     = gsp_pkg::ACT_TICK;
		b.pose_valid = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			b.goal_x = $urandom;
			b.goal_y = $urandom;
		end else if (r < 55) begin
			b.goal_x = sat32(spread(3 * tol + 8));
			b.goal_y = sat32(spread(3 * tol + 8));
		end else if (r < 85) begin
			b.goal_x = sat32(spread(tol / 2));
			b.goal_y = sat32(spread(tol / 2));
		end else begin
			// one axis on the distance bound, give or take one lsb
			edge_v = ($urandom_range(0, 1) ? tol : -tol) + spread(1);
			if ($urandom_range(0, 1)) begin
				b.goal_x = sat32(edge_v);
				b.goal_y = '0;
			end else begin
				b.goal_x = '0;
				b.goal_y = sat32(edge_v);
			end
		end
		r = $urandom_range(0, 99);
		if (r < 25) begin
			b.yaw_error = $urandom;
		end else if (r < 50) begin
			b.yaw_error = sat32(($urandom_range(0, 1) ? ang : -ang) + spread(1));
		end else if (r < 80) begin
			b.yaw_error = (ang > 0) ? sat32(spread(ang - 1)) : '0;
		end else begin
			b.yaw_error = sat32(spread(4 * ang + 8));
		end
		return b;
	endfunction

	task automatic queue_beat(gsp_pkg::tick_beat_t b, bit counts);
		tick_backlog.push_back(b);
		if (counts) n_random++;
	endtask

	// goal, a few ticks with noise, usually a closing tick that arrives
	task automatic queue_episode();
		gsp_pkg::tick_beat_t b;
		int                  n;
		int                  r;
		longint              tol;
		longint              ang;
		tol = longint'(64'(cfg_shadow[gsp_pkg::REG_DIST_TOLERANCE]));
		ang = longint'(64'(cfg_shadow[gsp_pkg::REG_ANGLE_TOLERANCE]));
		queue_beat(goal_beat(), 1'b1);
		n = $urandom_range(1, 8);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				b = random_tick();
				b.pose_valid = 1'b0;
				queue_beat(b, 1'b0);
			end else if (r < 15) begin
				queue_beat(goal_beat(), 1'b1);
			end else begin
				queue_beat(random_tick(), 1'b1);
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			queue_beat(make_beat(gsp_pkg::ACT_TICK, spread(tol / 2), spread(tol / 2),
				(ang > 0) ? spread(ang - 1) : 0, 1'b1), 1'b1);
		end
		// a tick that most likely finds the block disarmed
		if ($urandom_range(0, 4) == 0) queue_beat(random_tick(), 1'b0);
	endtask

	task automatic queue_random_phase();
		int start;
		start = n_random;
		while (n_random - start < ITEMS_PER_PHASE) queue_episode();
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_word_t val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_shadow[idx] = val;
	endtask

	task automatic load_setting(setting_t s);
		cfg_word_t v [8];
		case (s)
			SET_ALL_ONES: begin
				foreach (v[i]) v[i] = CFG_ONES;
			end
			SET_ALL_ZERO: begin
				foreach (v[i]) v[i] = '0;
			end
			SET_TYPICAL: begin
				v[gsp_pkg::REG_MAX_SPEED_X]     =
					cfg_word_t'($urandom_range(1 << 15, 3 << FRAC_BITS));
				v[gsp_pkg::REG_MAX_SPEED_Y]     =
					cfg_word_t'($urandom_range(1 << 15, 3 << FRAC_BITS));
				v[gsp_pkg::REG_MAX_SPEED_YAW]   =
					cfg_word_t'($urandom_range(1 << 15, 3 << FRAC_BITS));
				v[gsp_pkg::REG_GAIN_X]          = cfg_word_t'($urandom_range(0, 4 << FRAC_BITS));
				v[gsp_pkg::REG_GAIN_Y]          = cfg_word_t'($urandom_range(0, 4 << FRAC_BITS));
				v[gsp_pkg::REG_GAIN_YAW]        = cfg_word_t'($urandom_range(0, 4 << FRAC_BITS));
				v[gsp_pkg::REG_DIST_TOLERANCE]  =
					cfg_word_t'($urandom_range(1 << 12, 2 << FRAC_BITS));
				v[gsp_pkg::REG_ANGLE_TOLERANCE] = cfg_word_t'($urandom_range(1 << 10, 1 << 15));
			end
			SET_RAW: begin
				foreach (v[i]) v[i] = 31'($urandom);
			end
			SET_FINE_GAIN: begin
				// fractional gains exercise the floor on negative products,
				// zero angle tolerance means turning forever
				v[gsp_pkg::REG_MAX_SPEED_X]     = CFG_ONES;
				v[gsp_pkg::REG_MAX_SPEED_Y]     = CFG_ONES;
				v[gsp_pkg::REG_MAX_SPEED_YAW]   = CFG_ONES;
				v[gsp_pkg::REG_GAIN_X]          = cfg_word_t'($urandom_range(1, 65535));
				v[gsp_pkg::REG_GAIN_Y]          = cfg_word_t'($urandom_range(1, 65535));
				v[gsp_pkg::REG_GAIN_YAW]        = cfg_word_t'($urandom_range(1, 65535));
				v[gsp_pkg::REG_DIST_TOLERANCE]  = cfg_word_t'($urandom_range(0, 1 << FRAC_BITS));
				v[gsp_pkg::REG_ANGLE_TOLERANCE] = '0;
			end
			default: begin
				v[gsp_pkg::REG_MAX_SPEED_X]     = ONE_Q;
				v[gsp_pkg::REG_MAX_SPEED_Y]     = ONE_Q;
				v[gsp_pkg::REG_MAX_SPEED_YAW]   = cfg_word_t'(ONE_Q * 2);
				v[gsp_pkg::REG_GAIN_X]          = ONE_Q;
				v[gsp_pkg::REG_GAIN_Y]          = ONE_Q;
				v[gsp_pkg::REG_GAIN_YAW]        = ONE_Q;
				v[gsp_pkg::REG_DIST_TOLERANCE]  = cfg_word_t'((ONE_Q + 5) / 10);
				v[gsp_pkg::REG_ANGLE_TOLERANCE] = cfg_word_t'((ONE_Q * 5 + 50) / 100);
			end
		endcase
		foreach (v[i]) write_reg(cfg_idx_t'(i), v[i]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every command, then let goals and dropped ticks drain from the pipeline
	task automatic settle();
		while (tick_backlog.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// tick driver: bursts of random length, random gaps, payload held while stalled
	// ---------------------------------------------------------------
	int burst_left = 4;
	int gap_left   = 0;

	always @(negedge clk) begin : tick_driver
		bit took;
		took = (drained_cnt != accepted_cnt);
		if (took) begin
			void'(tick_backlog.pop_front());
			drained_cnt++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 16);
				// some bursts run straight into the next one
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
		end
		// a beat still waiting on stall keeps valid and payload as they are
		if (!tick_valid || took) begin
			if (!arst_n || tick_backlog.size() == 0) begin
				tick_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				tick_valid <= 1'b0;
			end else begin
				tick_valid <= 1'b1;
				tick       <= tick_backlog[0];
			end
		end
	end

	// ---------------------------------------------------------------
	// command receiver: stall pattern switching between modes of its own
	// ---------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          run_left   = 0;
	bit          run_high   = 1'b0;

	always @(negedge clk) begin : cmd_stall_pattern
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(40, 200);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE:  cmd_stall <= 1'b0;
			STALL_LIGHT: cmd_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: cmd_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 20);
					run_high = !run_high;
				end
				run_left--;
				cmd_stall <= run_high;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// monitor: check the command beat first, then predict from the tick beat
	// ---------------------------------------------------------------
	always @(posedge clk) begin : beat_sampler
		gsp_pkg::cmd_beat_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("command beat with no command expected: %p", cmd);
					fail_count++;
				end else begin
					want = expected_cmds.pop_front();
					n_checked++;
					if (cmd.vel_x !== want.vel_x) begin
						$error("vel_x: expected %0d, got %0d", want.vel_x, cmd.vel_x);
						fail_count++;
					end
					if (cmd.vel_y !== want.vel_y) begin
						$error("vel_y: expected %0d, got %0d", want.vel_y, cmd.vel_y);
						fail_count++;
					end
					if (cmd.vel_yaw !== want.vel_yaw) begin
						$error("vel_yaw: expected %0d, got %0d", want.vel_yaw, cmd.vel_yaw);
						fail_count++;
					end
					if (cmd.arrived !== want.arrived) begin
						$error("arrived: expected %0b, got %0b", want.arrived, cmd.arrived);
						fail_count++;
					end
				end
			end
			if (tick_valid && !tick_stall) begin
				predict_command(tick);
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d commands outstanding", cycle_cnt,
				expected_cmds.size());
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// sequence: reset, directed beats, then random phases under several settings
	// ---------------------------------------------------------------
	setting_t plan [6] = '{SET_ALL_ONES, SET_ALL_ZERO, SET_TYPICAL, SET_RAW, SET_FINE_GAIN,
		SET_DEFAULT};

	initial begin
		// register copy starts at the reset defaults
		cfg_shadow[gsp_pkg::REG_MAX_SPEED_X]     = ONE_Q;
		cfg_shadow[gsp_pkg::REG_MAX_SPEED_Y]     = ONE_Q;
		cfg_shadow[gsp_pkg::REG_MAX_SPEED_YAW]   = cfg_word_t'(ONE_Q * 2);
		cfg_shadow[gsp_pkg::REG_GAIN_X]          = ONE_Q;
		cfg_shadow[gsp_pkg::REG_GAIN_Y]          = ONE_Q;
		cfg_shadow[gsp_pkg::REG_GAIN_YAW]        = ONE_Q;
		cfg_shadow[gsp_pkg::REG_DIST_TOLERANCE]  = cfg_word_t'((ONE_Q + 5) / 10);
		cfg_shadow[gsp_pkg::REG_ANGLE_TOLERANCE] = cfg_word_t'((ONE_Q * 5 + 50) / 100);
		armed = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed beats at reset settings: tolerance 6554, angle 3277
		// tick while idle, then goal, then goal while armed, then a tick with no pose
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 100, 200, 300, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_GOAL, S32_MIN, S32_MAX, S32_MIN, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_GOAL, 0, 0, 0, 1'b0));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 50000, 50000, 0, 1'b0));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, S32_MAX, S32_MIN, S32_MAX, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, S32_MIN, 0, 0, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, -30001, 40000, -5, 1'b1));
		// on the distance bound, then just outside
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 6554, 0, 200000, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 6555, 0, 200000, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 0, -6554, S32_MIN, 1'b1));
		// yaw on the bound keeps turning
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 0, 0, 3277, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 0, 0, -3277, 1'b1));
		// arrival, then a tick that finds the block disarmed
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 100, -100, 3276, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 0, 0, 0, 1'b1));
		// diagonal arrival
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_GOAL, -1, -1, -1, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 4634, 4634, -3276, 1'b1));
		tick_backlog.push_back(make_beat(gsp_pkg::ACT_TICK, 0, 0, 0, 1'b0));
		queue_random_phase();
		settle();

		foreach (plan[i]) begin
			load_setting(plan[i]);
			queue_random_phase();
			settle();
		end

		$display("%0d tick beats over seven register settings, all-zero and all-ones among them",
			accepted_cnt);
		$display("%0d commands checked: %0d moving, %0d turning, %0d arrivals", n_checked,
			n_moving, n_turning, n_arrivals);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/gsp_pkg.sv
rtl/gsp_prod.sv
rtl/gsp_sat.sv
rtl/goal_seek_p_controller.sv
rtl/gsp_checker.sv
tb/goal_seek_p_controller_tb.sv
